/* rtl/core/msp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// msp_pkg: shared types and helpers for the max-sum partition block
// widths, ring pointer arithmetic and the control bundle of the multiply-add unit
// ----------------------------------------------------------------------------
package msp_pkg;

    localparam int MAX_PART = 16;
    localparam int VAL_W    = 30;
    localparam int SUM_W    = 40;
    localparam int CFG_W    = 5;
    localparam int PTR_W    = $clog2(MAX_PART);
    localparam int CNT_W    = $clog2(MAX_PART + 1);
    localparam int PROD_W   = VAL_W + CNT_W;

    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [VAL_W-1:0] val_t;
    typedef logic [SUM_W-1:0] sum_t;

    // control bundle from the sequencer to the shared multiply-add unit
    typedef struct packed {
        logic clear;
        logic issue;
        cnt_t len;
    } mac_ctl_t;

    // slot that lies off places behind head, off in 0..MAX_PART
    function automatic ptr_t ring_back(input ptr_t head, input cnt_t off);
        logic [CNT_W:0] o;
        logic [CNT_W:0] h;
        o = (off >= CNT_W'(MAX_PART)) ? '0 : {1'b0, off};
        h = (CNT_W + 1)'(head);
        if (h >= o) begin
            return PTR_W'(h - o);
        end
        return PTR_W'(h + (CNT_W + 1)'(MAX_PART) - o);
    endfunction

    function automatic ptr_t ring_next(input ptr_t head);
        return (head == PTR_W'(MAX_PART - 1)) ? '0 : PTR_W'(head + 1'b1);
    endfunction

endpackage
`default_nettype wire

/* rtl/core/msp_window.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// msp_window: rings of recent elements and recent prefix bests
// one write port and one registered read port per ring
// ----------------------------------------------------------------------------
module msp_window (
    input  wire logic          clk,
    input  wire logic          val_we,
    input  wire msp_pkg::ptr_t val_wptr,
    input  wire msp_pkg::val_t val_wdata,
    input  wire msp_pkg::ptr_t val_rptr,
    output msp_pkg::val_t      val_rdata,
    input  wire logic          pre_we,
    input  wire msp_pkg::ptr_t pre_wptr,
    input  wire msp_pkg::sum_t pre_wdata,
    input  wire msp_pkg::ptr_t pre_rptr,
    output msp_pkg::sum_t      pre_rdata
);
    import msp_pkg::*;

    val_t recent_reg [MAX_PART];
    sum_t prefix_reg [MAX_PART];
    val_t val_rdata_reg;
    sum_t pre_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            recent_reg[val_wptr] <= val_wdata;
        end
        if (pre_we)
        begin
            prefix_reg[pre_wptr] <= pre_wdata;
        end
        val_rdata_reg <= recent_reg[val_rptr];
        pre_rdata_reg <= prefix_reg[pre_rptr];
    end

    assign val_rdata = val_rdata_reg;
    assign pre_rdata = pre_rdata_reg;

endmodule
`default_nettype wire

/* rtl/core/msp_mac.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// msp_mac: shared running-max, multiply-add and compare unit
// stage one multiplies the running max by the length, stage two adds and keeps the best
// ----------------------------------------------------------------------------
module msp_mac (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire msp_pkg::mac_ctl_t ctl,
    input  wire msp_pkg::val_t     elem,
    input  wire msp_pkg::sum_t     prev_best,
    output msp_pkg::sum_t          best
);
    import msp_pkg::*;

    localparam logic [SUM_W:0] SAT = (SUM_W + 1)'({SUM_W{1'b1}});

    val_t              run_max_reg;
    logic [PROD_W-1:0] prod_reg;
    sum_t              prev_best_reg;
    logic              pv_reg;
    sum_t              best_reg;

    val_t              run_max_next;
    logic [SUM_W:0]    cand_raw;
    sum_t              cand;

    assign run_max_next = (elem > run_max_reg) ? elem : run_max_reg;
    assign cand_raw     = (SUM_W + 1)'(prod_reg) + (SUM_W + 1)'(prev_best_reg);
    assign cand         = (cand_raw > SAT) ? SAT[SUM_W-1:0] : cand_raw[SUM_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= 1'b0;
        end
        else
        begin
            pv_reg <= ctl.issue & ~ctl.clear;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.clear)
        begin
            run_max_reg <= '0;
            best_reg    <= '0;
        end
        else
        begin
            if (ctl.issue)
            begin
                run_max_reg   <= run_max_next;
                prod_reg      <= PROD_W'(run_max_next) * PROD_W'(ctl.len);
                prev_best_reg <= prev_best;
            end
            if (pv_reg && (cand > best_reg))
            begin
                best_reg <= cand;
            end
        end
    end

    assign best = best_reg;

endmodule
`default_nettype wire

/* rtl/core/max_sum_partition_dp_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// max_sum_partition_dp_top: streaming partition of an array for maximum sum
// elements arrive one per item; on the last one the best partition total leaves
// ----------------------------------------------------------------------------
//  channel   | signals                               | direction
//  ----------+---------------------------------------+----------
//  input     | in_valid, in_ready, value, last       | in
//  result    | out_valid, out_ready, best_sum        | out
//  config    | cfg_valid, cfg_ready, max_part        | in
//
//  an element walks lim candidate lengths, lim = min(max_part, elements so far + 1),
//  with max_part 0 taken as 1 and capped at MAX_PART, so at most 16; the walk reads
//  one candidate length per cycle from the window, the shared multiply-add unit
//  takes each from the registered read, then drain, settle and write-back follow
//  reset clears the window count, ring head and output valid; max_part resets to 1
//  in_ready is high only between items; a last element waits in write-back
//  while an earlier result is still not taken
// ----------------------------------------------------------------------------
module max_sum_partition_dp_top (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [msp_pkg::VAL_W-1:0]  value,
    input  wire logic                       last,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [msp_pkg::SUM_W-1:0]       best_sum,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [msp_pkg::CFG_W-1:0]  max_part
);
    import msp_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_WALK   = 3'd1;
    localparam logic [2:0] ST_DRAIN  = 3'd2;
    localparam logic [2:0] ST_SETTLE = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [CFG_W-1:0] max_part_reg;
    ptr_t             head_reg;
    cnt_t             seen_reg;
    cnt_t             lim_reg;
    cnt_t             len_reg;
    logic             rd_valid_reg;
    cnt_t             rd_len_reg;
    logic             last_reg;
    logic             out_valid_reg;
    sum_t             best_sum_reg;

    logic             accept;
    logic             finish;
    cnt_t             k_eff;
    logic [CNT_W:0]   seen_p1;
    cnt_t             lim_next;

    mac_ctl_t         mac_ctl;
    val_t             elem;
    sum_t             pre_rd;
    sum_t             prev_best;
    sum_t             best;
    ptr_t             val_rptr;
    ptr_t             pre_rptr;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid & in_ready;
    assign cfg_ready = 1'b1;

    // write-back fires unless a last result would overwrite one still waiting
    assign finish = (state_reg == ST_FINISH) &&
                    !(last_reg && out_valid_reg && !out_ready);

    // piece length limit: zero means one, above the ring depth saturates
    always_comb
    begin
        if (max_part_reg == '0)
        begin
            k_eff = cnt_t'(1);
        end
        else if (32'(max_part_reg) > MAX_PART)
        begin
            k_eff = cnt_t'(MAX_PART);
        end
        else
        begin
            k_eff = cnt_t'(max_part_reg);
        end
        seen_p1  = (CNT_W + 1)'(seen_reg) + 1'b1;
        lim_next = (seen_p1 > (CNT_W + 1)'(k_eff)) ? k_eff : seen_p1[CNT_W-1:0];
    end

    // walk back: element len-1 slots back, prefix best len slots back
    // read data lands in the next cycle, tagged with rd_len_reg
    assign val_rptr  = ring_back(head_reg, cnt_t'(len_reg - 1'b1));
    assign pre_rptr  = ring_back(head_reg, len_reg);
    assign prev_best = (rd_len_reg > seen_reg) ? '0 : pre_rd;

    assign mac_ctl.clear = accept;
    assign mac_ctl.issue = rd_valid_reg;
    assign mac_ctl.len   = rd_len_reg;

    msp_window u_window (
        .clk       (clk),
        .val_we    (accept),
        .val_wptr  (head_reg),
        .val_wdata (value),
        .val_rptr  (val_rptr),
        .val_rdata (elem),
        .pre_we    (finish),
        .pre_wptr  (head_reg),
        .pre_wdata (best),
        .pre_rptr  (pre_rptr),
        .pre_rdata (pre_rd)
    );

    msp_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (mac_ctl),
        .elem      (elem),
        .prev_best (prev_best),
        .best      (best)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (len_reg == lim_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_SETTLE;
            end
            ST_SETTLE:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            max_part_reg  <= CFG_W'(1);
            head_reg      <= '0;
            seen_reg      <= '0;
            lim_reg       <= cnt_t'(1);
            len_reg       <= cnt_t'(1);
            rd_valid_reg  <= 1'b0;
            rd_len_reg    <= cnt_t'(1);
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= (state_reg == ST_WALK);
            rd_len_reg   <= len_reg;
            if (cfg_valid && cfg_ready)
            begin
                max_part_reg <= max_part;
            end
            if (accept)
            begin
                lim_reg  <= lim_next;
                len_reg  <= cnt_t'(1);
                last_reg <= last;
            end
            else if ((state_reg == ST_WALK) && (len_reg != lim_reg))
            begin
                len_reg <= cnt_t'(len_reg + 1'b1);
            end
            // result leaves when taken; a new one is loaded on last write-back
            if (finish && last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (finish)
            begin
                if (last_reg)
                begin
                    head_reg <= '0;
                    seen_reg <= '0;
                end
                else
                begin
                    head_reg <= ring_next(head_reg);
                    if (seen_reg < cnt_t'(MAX_PART))
                    begin
                        seen_reg <= cnt_t'(seen_reg + 1'b1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish && last_reg)
        begin
            best_sum_reg <= best;
        end
    end

    assign out_valid = out_valid_reg;
    assign best_sum  = best_sum_reg;

endmodule
`default_nettype wire
